// ===== design/bdpc_pkg.sv =====
// shared types and constants for the button debounce press classifier
package bdpc_pkg;

    localparam int unsigned CFG_W    = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd15;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // register select is paddr bit 2
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_cfg;

    typedef struct packed {
        logic press;
        logic short_press;
        logic release_ev;
        logic long_press;
    } t_events;

endpackage

// ===== design/bdpc_if.sv =====
// valid/ready channels for poll words and event words
interface bdpc_in_if;
    import bdpc_pkg::*;
    logic              valid;
    logic              ready;
    logic              pin_level;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bdpc_out_if;
    logic valid;
    logic ready;
    logic press_event;
    logic short_press_event;
    logic release_event;
    logic long_press_event;

    modport source (output valid, output press_event, output short_press_event,
                    output release_event, output long_press_event, input ready);
    modport sink   (input valid, input press_event, input short_press_event,
                    input release_event, input long_press_event, output ready);
endinterface

// ===== design/bdpc_apb_regs.sv =====
// apb register file holding the debounce and long press thresholds
module bdpc_apb_regs
    import bdpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    logic w_wr;
    logic w_sel;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_sel  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_RESET;
            r_cfg.long_press_ms <= LONG_PRESS_RESET;
        end else if (w_wr) begin
            if (w_sel == REG_DEBOUNCE) begin
                r_cfg.debounce_ms <= pwdata[CFG_W-1:0];
            end else begin
                r_cfg.long_press_ms <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        case (w_sel)
            REG_DEBOUNCE:   prdata = {{(PDATA_W-CFG_W){1'b0}}, r_cfg.debounce_ms};
            REG_LONG_PRESS: prdata = {{(PDATA_W-CFG_W){1'b0}}, r_cfg.long_press_ms};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/button_debounce_press_classifier_unit.sv =====
// top level: button debounce filter and short/long press classifier
//
// usage
//   i_in_word carries one poll per word: raw active-low pin level and the
//   current millisecond tick. o_out_word carries one event word per poll
//   with press, short press, release and long press flags.
//   the apb port holds debounce_ms (0x0) and long_press_ms (0x4); write them
//   only while no poll is in flight.
// pipeline
//   a poll is taken into an input register, evaluated against the state
//   registers and its event word lands in the output register.
//   one poll per cycle while o_out_word.ready stays high, set by the state update loop.
// reset
//   synchronous active-low; both levels read as released, no debounce timer
//   running, no press held, thresholds back to 15 ms and 1000 ms.
// stalls
//   while the receiver holds ready low the event word waits in the output
//   register and one more poll can wait in the input register; i_in_word
//   ready drops only once both are full.
module button_debounce_press_classifier_unit
    import bdpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    bdpc_in_if.sink            i_in_word,
    bdpc_out_if.source         o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg w_cfg;

    bdpc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input register stage
    logic              r_s1_valid;
    logic              r_s1_pin;
    logic [TIME_W-1:0] r_s1_now;

    // output register stage
    logic              r_out_valid;
    t_events           r_out_ev;

    // block state
    logic              r_filtered;
    logic              r_deb_active;
    logic [TIME_W-1:0] r_deb_start;
    logic              r_stable;
    logic              r_held;
    logic [TIME_W-1:0] r_press_start;

    logic w_advance;
    logic w_take;
    logic w_step;

    // stage 1 moves on when the output slot is free or being drained
    assign w_advance       = !r_out_valid || o_out_word.ready;
    assign i_in_word.ready = !r_s1_valid || w_advance;
    assign w_take          = i_in_word.valid && i_in_word.ready;
    assign w_step          = r_s1_valid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_word.ready) begin
            r_s1_valid <= i_in_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_pin <= i_in_word.pin_level;
            r_s1_now <= i_in_word.now_ms;
        end
    end

    // next-state evaluation for the poll in stage 1
    logic              w_lvl_change;
    logic              w_act;
    logic [TIME_W-1:0] w_dstart;
    logic [TIME_W-1:0] w_deb_elapsed;
    logic              w_commit;
    logic              n_stable;
    logic              n_deb_active;
    logic              w_edge;
    logic              w_fall;
    logic              w_rise;
    logic [TIME_W-1:0] w_hold_elapsed;
    logic              w_short;
    logic              w_held_mid;
    logic              w_long;
    logic              n_held;
    t_events           n_ev;

    always_comb begin
        // debounce filter: a raw change restarts the timer
        w_lvl_change  = r_s1_pin != r_filtered;
        w_act         = w_lvl_change || r_deb_active;
        w_dstart      = w_lvl_change ? r_s1_now : r_deb_start;
        w_deb_elapsed = r_s1_now - w_dstart;
        w_commit      = w_act && (w_deb_elapsed >= {{(TIME_W-CFG_W){1'b0}}, w_cfg.debounce_ms});
        n_stable      = w_commit ? r_s1_pin : r_stable;
        n_deb_active  = w_act && !w_commit;

        // edges of the stable level
        w_edge = n_stable != r_stable;
        w_fall = w_edge && (n_stable == LEVEL_PRESSED);
        w_rise = w_edge && (n_stable == LEVEL_RELEASED);

        // hold time measured from the old press start (unchanged on release)
        w_hold_elapsed = r_s1_now - r_press_start;
        w_short        = w_rise &&
                         (w_hold_elapsed <= {{(TIME_W-CFG_W){1'b0}}, w_cfg.long_press_ms});

        // on a fresh press the elapsed time is zero
        w_held_mid = w_fall || (r_held && !w_rise);
        w_long     = w_held_mid &&
                     (w_fall ? (w_cfg.long_press_ms == '0)
                             : (w_hold_elapsed >= {{(TIME_W-CFG_W){1'b0}},
                                                   w_cfg.long_press_ms}));
        n_held     = w_held_mid && !w_long;

        n_ev.press       = w_fall;
        n_ev.short_press = w_short;
        n_ev.release_ev  = w_rise;
        n_ev.long_press  = w_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filtered   <= LEVEL_RELEASED;
            r_deb_active <= 1'b0;
            r_deb_start  <= '0;
            r_stable     <= LEVEL_RELEASED;
            r_held       <= 1'b0;
            r_press_start <= '0;
        end else if (w_step) begin
            r_filtered   <= r_s1_pin;
            r_deb_active <= n_deb_active;
            r_deb_start  <= w_dstart;
            r_stable     <= n_stable;
            r_held       <= n_held;
            if (w_fall) begin
                r_press_start <= r_s1_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_ev <= n_ev;
        end
    end

    assign o_out_word.valid             = r_out_valid;
    assign o_out_word.press_event       = r_out_ev.press;
    assign o_out_word.short_press_event = r_out_ev.short_press;
    assign o_out_word.release_event     = r_out_ev.release_ev;
    assign o_out_word.long_press_event  = r_out_ev.long_press;

    // press and release never share a word
    a_press_xor_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_ev.press && r_out_ev.release_ev))
        else $error("press and release in the same word");

    // a short press only comes with a release
    a_short_needs_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ev.short_press) |-> r_out_ev.release_ev)
        else $error("short press without release");

    // long press never fires on a release word
    a_long_not_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ev.release_ev) |-> !r_out_ev.long_press)
        else $error("long press on release");

    // held only while the stable level is pressed
    a_held_when_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_stable == LEVEL_PRESSED))
        else $error("held flag set while released");

    // an empty output slot always lets a new poll in
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in_word.ready)
        else $error("input stalled with empty output");

endmodule

// ===== dv/button_debounce_press_classifier_unit_test.sv =====
// self-checking bench for the button debounce press classifier: random polls, stalls, apb setup
module button_debounce_press_classifier_unit_test;
    import bdpc_pkg::*;

    localparam int unsigned POLL_COUNT     = 1950;
    localparam int unsigned NUM_PHASES     = 10;
    localparam int unsigned HOLD_CYCLES    = 64;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned REPORT_LIMIT   = 10;

    typedef struct packed {
        logic              lvl;
        logic [TIME_W-1:0] now;
    } t_poll;

    // receiver back-pressure styles
    typedef enum logic [1:0] {
        RX_FLOW,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_mode;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // channels, driven from bench-local registers so they are known from time zero
    bdpc_in_if  in_ch ();
    bdpc_out_if out_ch ();

    logic              tx_valid = 1'b0;
    logic              tx_level = LEVEL_RELEASED;
    logic [TIME_W-1:0] tx_now   = '0;
    logic              rx_ready = 1'b1;

    assign in_ch.valid     = tx_valid;
    assign in_ch.pin_level = tx_level;
    assign in_ch.now_ms    = tx_now;
    assign out_ch.ready    = rx_ready;

    // apb configuration port
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    button_debounce_press_classifier_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (in_ch),
        .o_out_word (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // predictor state, mirrors the block after reset
    logic [CFG_W-1:0]  cfg_debounce = DEBOUNCE_RESET;
    logic [CFG_W-1:0]  cfg_long     = LONG_PRESS_RESET;
    logic              raw_level    = LEVEL_RELEASED;
    logic              settling     = 1'b0;
    logic [TIME_W-1:0] settle_t0    = '0;
    logic              steady_level = LEVEL_RELEASED;
    logic              last_steady  = LEVEL_RELEASED;
    logic              long_armed   = 1'b0;
    logic [TIME_W-1:0] hold_t0      = '0;

    // bench bookkeeping
    t_poll       pending_polls[$];
    t_events     expected_events[$];
    int unsigned n_polls      = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_reqs    = 0;
    logic        in_taken     = 1'b0;
    logic        tx_steady    = 1'b0;
    logic [TIME_W-1:0] tick   = '0;

    // one poll through the debounce filter and the edge/hold classifier
    function automatic t_events classify_poll(input logic lvl, input logic [TIME_W-1:0] now);
        t_events           ev;
        logic [TIME_W-1:0] dt;
        ev = '0;
        // any raw change restarts the settle timer
        if (lvl != raw_level) begin
            raw_level = lvl;
            settling  = 1'b1;
            settle_t0 = now;
        end
        dt = now - settle_t0;
        if (settling && dt >= TIME_W'(cfg_debounce)) begin
            steady_level = raw_level;
            settling     = 1'b0;
        end
        // edges of the settled level
        if (steady_level != last_steady) begin
            if (steady_level == LEVEL_PRESSED) begin
                long_armed = 1'b1;
                ev.press   = 1'b1;
                hold_t0    = now;
            end else begin
                dt = now - hold_t0;
                ev.short_press = (dt <= TIME_W'(cfg_long));
                ev.release_ev  = 1'b1;
                long_armed     = 1'b0;
            end
            last_steady = steady_level;
        end
        // long hold fires once per press, wrap-aware elapsed time
        dt = now - hold_t0;
        if (long_armed && dt >= TIME_W'(cfg_long)) begin
            ev.long_press = 1'b1;
            long_armed    = 1'b0;
        end
        return ev;
    endfunction

    // monitor: predict on every accepted poll, check every accepted event word
    always @(posedge i_clk) begin
        t_events got;
        t_events want;
        logic    moved;
        in_taken = 1'b0;
        moved    = 1'b0;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                got = {out_ch.press_event, out_ch.short_press_event,
                       out_ch.release_event, out_ch.long_press_event};
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected event word p=%b s=%b r=%b l=%b", $realtime,
                                 got.press, got.short_press, got.release_ev, got.long_press);
                end else begin
                    want = expected_events.pop_front();
                    if (got.press !== want.press || got.short_press !== want.short_press ||
                        got.release_ev !== want.release_ev ||
                        got.long_press !== want.long_press) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: event mismatch expected p=%b s=%b r=%b l=%b, ",
                                      "got p=%b s=%b r=%b l=%b"},
                                     $realtime, want.press, want.short_press, want.release_ev,
                                     want.long_press, got.press, got.short_press,
                                     got.release_ev, got.long_press);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                moved    = 1'b1;
                in_taken = 1'b1;
                expected_events.push_back(classify_poll(in_ch.pin_level, in_ch.now_ms));
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // poll driver: bursts of random length with random gaps outside steady phases, changes on the falling edge
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin
        t_poll cur;
        if (i_rst_n && (!tx_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                tx_valid <= 1'b0;
            end else if (pending_polls.size() > 0) begin
                cur = pending_polls.pop_front();
                tx_valid <= 1'b1;
                tx_level <= cur.lvl;
                tx_now   <= cur.now;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = tx_steady ? 0 : $urandom_range(1, 6);
                end
            end else begin
                tx_valid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern, plus a long hold-off on request to back up the pipe
    t_rx_mode    rx_mode   = RX_FLOW;
    int unsigned mode_left = 0;
    int unsigned hold_left = 0;
    int unsigned hold_seen = 0;
    int unsigned rx_beat   = 0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            rx_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            rx_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 160);
            end else begin
                mode_left--;
            end
            rx_beat++;
            case (rx_mode)
                RX_FLOW:     rx_ready <= 1'b1;
                RX_RANDOM:   rx_ready <= ($urandom_range(0, 99) >= 30);
                default:     rx_ready <= ((rx_beat % 5) >= 2);
            endcase
        end
    end

    // watchdog: nothing accepted for too long ends the run
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    // stimulus helpers
    task automatic push_poll(input logic lvl, input logic [TIME_W-1:0] now);
        pending_polls.push_back('{lvl: lvl, now: now});
        n_polls++;
    endtask

    // sender pauses until every expected word is back
    task automatic wait_drained();
        while (pending_polls.size() != 0 || tx_valid || expected_events.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic reg_sel,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // program both thresholds, mirror them, and read them back
    task automatic set_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng);
        logic [PDATA_W-1:0] rd;
        apb_xfer(1'b1, REG_DEBOUNCE, PDATA_W'(deb), rd);
        apb_xfer(1'b1, REG_LONG_PRESS, PDATA_W'(lng), rd);
        cfg_debounce = deb;
        cfg_long     = lng;
        apb_xfer(1'b0, REG_DEBOUNCE, '0, rd);
        if (rd[CFG_W-1:0] !== deb) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: debounce_ms readback expected %0d got %0d", $realtime, deb,
                         rd[CFG_W-1:0]);
        end
        apb_xfer(1'b0, REG_LONG_PRESS, '0, rd);
        if (rd[CFG_W-1:0] !== lng) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: long_press_ms readback expected %0d got %0d", $realtime, lng,
                         rd[CFG_W-1:0]);
        end
    endtask

    // hold one level for at least dur ms, sometimes landing exactly on dur
    task automatic settle(input logic lvl, input logic [TIME_W-1:0] dur);
        logic [TIME_W-1:0] t0;
        int unsigned       step_max;
        t0       = tick;
        step_max = dur / 4 + 1;
        push_poll(lvl, tick);
        while (tick - t0 < dur) begin
            tick = tick + $urandom_range(0, step_max);
            if (tick - t0 > dur && $urandom_range(0, 1))
                tick = t0 + dur;
            push_poll(lvl, tick);
        end
    endtask

    // contact bounce: a few quick random levels
    task automatic chatter();
        int unsigned n;
        n = $urandom_range(0, 3);
        repeat (n) begin
            tick = tick + $urandom_range(0, 3);
            push_poll(1'($urandom_range(0, 1)), tick);
        end
    endtask

    // well-formed press and release with hold time around the long threshold
    task automatic press_sequence();
        logic [TIME_W-1:0] hold;
        case ($urandom_range(0, 3))
            0:       hold = TIME_W'(cfg_long / 2);
            1:       hold = TIME_W'(cfg_long);
            2:       hold = cfg_long + $urandom_range(1, 40);
            default: hold = $urandom_range(0, 2 * cfg_long + 20);
        endcase
        chatter();
        settle(LEVEL_PRESSED, cfg_debounce + hold);
        chatter();
        settle(LEVEL_RELEASED, cfg_debounce + $urandom_range(0, 30));
    endtask

    // stray polls: random level, tick random, slightly back or far ahead
    task automatic noise_polls();
        int unsigned n;
        n = $urandom_range(1, 3);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0:       push_poll(1'($urandom_range(0, 1)), $urandom);
                1:       push_poll(1'($urandom_range(0, 1)), tick - $urandom_range(1, 100));
                default: push_poll(1'($urandom_range(0, 1)), tick + $urandom_range(0, 100000));
            endcase
        end
    endtask

    // main sequence
    initial begin
        logic [CFG_W-1:0] deb;
        logic [CFG_W-1:0] lng;
        int unsigned      phase_target;
        int unsigned      pick;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset thresholds 15 / 1000
        push_poll(LEVEL_RELEASED, 32'd0);
        push_poll(LEVEL_PRESSED, 32'd10);           // raw fall starts the timer
        push_poll(LEVEL_RELEASED, 32'd12);          // bounce back, nothing settles
        push_poll(LEVEL_PRESSED, 32'd20);
        push_poll(LEVEL_PRESSED, 32'd35);           // held 15 ms: press
        push_poll(LEVEL_PRESSED, 32'd1035);         // held 1000 ms: long press
        push_poll(LEVEL_RELEASED, 32'd1040);
        push_poll(LEVEL_RELEASED, 32'd1055);        // release after long, not short
        push_poll(LEVEL_PRESSED, 32'd2000);
        push_poll(LEVEL_PRESSED, 32'd2015);         // press at 2015
        push_poll(LEVEL_RELEASED, 32'd3000);
        push_poll(LEVEL_RELEASED, 32'd3015);        // hold exactly at threshold is short
        push_poll(LEVEL_RELEASED, 32'hFFFF_FFFF);   // all-ones tick
        push_poll(LEVEL_PRESSED, 32'hFFFF_FFF8);    // timer across the wrap
        push_poll(LEVEL_PRESSED, 32'h0000_0007);    // press after wrap
        push_poll(LEVEL_PRESSED, 32'h0000_0005);    // tick backwards reads as long hold
        push_poll(LEVEL_RELEASED, 32'h0000_0006);
        push_poll(LEVEL_RELEASED, 32'h0000_0000);   // backwards again: release, never short
        wait_drained();

        // directed, zero debounce and zero long threshold
        set_thresholds('0, '0);
        push_poll(LEVEL_PRESSED, 32'd100);          // press and long on one poll
        push_poll(LEVEL_RELEASED, 32'd100);         // release on the press tick is short
        push_poll(LEVEL_PRESSED, 32'd200);
        push_poll(LEVEL_RELEASED, 32'd201);         // one tick later is not short
        wait_drained();

        // random phases over several threshold settings, extremes first
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       begin deb = 16'd0;     lng = 16'd0;     end
                1:       begin deb = 16'hFFFF;  lng = 16'hFFFF;  end
                2:       begin deb = 16'd0;     lng = 16'hFFFF;  end
                3:       begin deb = 16'hFFFF;  lng = 16'd0;     end
                4:       begin deb = DEBOUNCE_RESET; lng = LONG_PRESS_RESET; end
                default: begin
                    deb = CFG_W'($urandom_range(0, 25));
                    lng = CFG_W'($urandom_range(0, 300));
                end
            endcase
            set_thresholds(deb, lng);
            tick = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                               : $urandom;
            tx_steady = ((ph % 3) == 2);
            // back the pipe up once with a long receiver hold-off
            if (ph == 6)
                hold_reqs++;
            phase_target = 25 + ((POLL_COUNT - 25) * (ph + 1)) / NUM_PHASES;
            while (n_polls < phase_target) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    press_sequence();
                end else if (pick < 85) begin
                    // press held for half the debounce time, too short to settle unless debounce is zero
                    settle(LEVEL_PRESSED, TIME_W'(cfg_debounce / 2));
                    settle(LEVEL_RELEASED, cfg_debounce + 5);
                end else begin
                    noise_polls();
                end
            end
            wait_drained();
        end

        // let any stray word show up, then judge
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_events.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
